>>> hw/rtl/shabh_pkg.sv
// shared constants, types and round functions for the sha-256/224 byte hasher
`timescale 1ns / 1ps

package shabh_pkg;

   localparam int WORD_W  = 32;
   localparam int BYTE_W  = 8;
   localparam int BLK_W   = 512;
   localparam int FILL_W  = 6;
   localparam int CNT_W   = 61;
   localparam int LEN_W   = 64;
   localparam int RND_W   = 6;
   localparam int IDX_W   = 3;
   localparam int NWORDS  = 8;

   localparam logic [FILL_W-1:0] FILL_MAX  = 6'd63;
   localparam logic [FILL_W-1:0] LEN_POS   = 6'd56;
   localparam logic [RND_W-1:0]  RND_LAST  = 6'd63;
   localparam logic [BYTE_W-1:0] PAD_MARK  = 8'h80;
   localparam logic [IDX_W-1:0]  LAST_256  = 3'd7;
   localparam logic [IDX_W-1:0]  LAST_224  = 3'd6;

   localparam logic MODE_256 = 1'b0;
   localparam logic MODE_224 = 1'b1;

   localparam logic ACT_ABSORB = 1'b0;
   localparam logic ACT_FINISH = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAD   = 6'b000010,
      ST_LEN   = 6'b000100,
      ST_ROUND = 6'b001000,
      ST_ADD   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type IV256 [NWORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam word_type IV224 [NWORDS] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   localparam word_type ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic word_type bsig0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type bsig1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type ssig0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ (x >> 3);
   endfunction

   function automatic word_type ssig1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ (x >> 10);
   endfunction

   function automatic word_type init_word(input logic mode, input logic [IDX_W-1:0] idx);
      return (mode == MODE_224) ? IV224[idx] : IV256[idx];
   endfunction

endpackage

>>> hw/rtl/sha256_byte_hasher.sv
// sha-256/224 byte-stream hasher with one shared round unit
//
//  channel | dir | handshake              | payload
//  req     | in  | req_valid / req_ready  | req_action, req_data_byte
//  rsp     | out | rsp_valid / rsp_ready  | rsp_digest_word, rsp_word_index, rsp_last
//  csr     | in  | csr_valid / csr_ready  | csr_digest_mode
//
//  an absorb byte is taken only when idle; the 64th byte of a block starts a compression of
//  64 rounds on the shared round unit and one chaining add, during which no byte is taken
//  finish: pad mark and zero bytes, compressing a full block if needed, then the length bytes,
//  a compression of the final block, and then the digest words on rsp, one per transfer
//  reset loads the sha-256 initial words and selects sha-256; no clearing pass
//  a stalled rsp holds its output register; req and csr are taken only when idle
`timescale 1ns / 1ps

module sha256_byte_hasher (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_action,
   input  logic [shabh_pkg::BYTE_W-1:0]      req_data_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [shabh_pkg::WORD_W-1:0]      rsp_digest_word,
   output logic [shabh_pkg::IDX_W-1:0]       rsp_word_index,
   output logic                              rsp_last,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_digest_mode
);
   import shabh_pkg::*;

   state_type            state_ff, state_in;
   state_type            ret_ff, ret_in;
   logic                 mode_ff, mode_in;
   word_type             h_ff [NWORDS];
   word_type             h_in [NWORDS];
   word_type             v_ff [NWORDS];
   word_type             v_in [NWORDS];
   logic [BLK_W-1:0]     blk_ff, blk_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic [LEN_W-1:0]     len_ff, len_in;
   logic [RND_W-1:0]     rnd_ff, rnd_in;
   logic [IDX_W-1:0]     oidx_ff, oidx_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   word_type             rsp_word_ff, rsp_word_in;
   logic [IDX_W-1:0]     rsp_idx_ff, rsp_idx_in;
   logic                 rsp_last_ff, rsp_last_in;

   word_type             w0, w1, w9, w14, w_new;
   word_type             t1, t2, ch, maj;
   logic [IDX_W-1:0]     last_idx;
   logic                 out_last;

   // message schedule taps and one round
   always_comb begin
      w0    = blk_ff[BLK_W-1 -: WORD_W];
      w1    = blk_ff[BLK_W-1-WORD_W -: WORD_W];
      w9    = blk_ff[BLK_W-1-9*WORD_W -: WORD_W];
      w14   = blk_ff[BLK_W-1-14*WORD_W -: WORD_W];
      w_new = w0 + ssig0(w1) + w9 + ssig1(w14);
      ch    = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      maj   = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      t1    = v_ff[7] + bsig1(v_ff[4]) + ch + ROUND_K[rnd_ff] + w0;
      t2    = bsig0(v_ff[0]) + maj;
   end

   assign last_idx  = (mode_ff == MODE_224) ? LAST_224 : LAST_256;
   assign out_last  = (oidx_ff == last_idx);
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      mode_in      = mode_ff;
      h_in         = h_ff;
      v_in         = v_ff;
      blk_in       = blk_ff;
      fill_in      = fill_ff;
      cnt_in       = cnt_ff;
      len_in       = len_ff;
      rnd_in       = rnd_ff;
      oidx_in      = oidx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (csr_valid) begin
               mode_in = csr_digest_mode;
               for (int i = 0; i < NWORDS; i++) begin
                  h_in[i] = init_word(csr_digest_mode, IDX_W'(i));
               end
               fill_in = '0;
               cnt_in  = '0;
            end else if (req_valid) begin
               fill_in = FILL_W'(fill_ff + 1'b1);
               if (req_action == ACT_ABSORB) begin
                  blk_in = {blk_ff[BLK_W-BYTE_W-1:0], req_data_byte};
                  cnt_in = CNT_W'(cnt_ff + 1'b1);
                  ret_in = ST_IDLE;
               end else begin
                  blk_in   = {blk_ff[BLK_W-BYTE_W-1:0], PAD_MARK};
                  len_in   = {cnt_ff, 3'b000};
                  ret_in   = ST_PAD;
                  state_in = ST_PAD;
               end
               if (fill_ff == FILL_MAX) begin
                  v_in     = h_ff;
                  rnd_in   = '0;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_PAD: begin
            if (fill_ff == LEN_POS) begin
               state_in = ST_LEN;
            end else begin
               blk_in  = {blk_ff[BLK_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
               fill_in = FILL_W'(fill_ff + 1'b1);
               if (fill_ff == FILL_MAX) begin
                  v_in     = h_ff;
                  rnd_in   = '0;
                  ret_in   = ST_PAD;
                  state_in = ST_ROUND;
               end
            end
         end
         ST_LEN: begin
            blk_in  = {blk_ff[BLK_W-BYTE_W-1:0], len_ff[LEN_W-1 -: BYTE_W]};
            len_in  = {len_ff[LEN_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            fill_in = FILL_W'(fill_ff + 1'b1);
            if (fill_ff == FILL_MAX) begin
               v_in     = h_ff;
               rnd_in   = '0;
               ret_in   = ST_OUT;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            v_in[7] = v_ff[6];
            v_in[6] = v_ff[5];
            v_in[5] = v_ff[4];
            v_in[4] = v_ff[3] + t1;
            v_in[3] = v_ff[2];
            v_in[2] = v_ff[1];
            v_in[1] = v_ff[0];
            v_in[0] = t1 + t2;
            blk_in  = {blk_ff[BLK_W-WORD_W-1:0], w_new};
            rnd_in  = RND_W'(rnd_ff + 1'b1);
            if (rnd_ff == RND_LAST) begin
               rnd_in   = '0;
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < NWORDS; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
            end
            state_in = ret_ff;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = h_ff[oidx_ff];
               rsp_idx_in   = oidx_ff;
               rsp_last_in  = out_last;
               oidx_in      = IDX_W'(oidx_ff + 1'b1);
               if (out_last) begin
                  for (int i = 0; i < NWORDS; i++) begin
                     h_in[i] = init_word(mode_ff, IDX_W'(i));
                  end
                  oidx_in  = '0;
                  fill_in  = '0;
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         mode_ff      <= MODE_256;
         for (int i = 0; i < NWORDS; i++) begin
            h_ff[i] <= IV256[i];
         end
         fill_ff      <= '0;
         cnt_ff       <= '0;
         rnd_ff       <= '0;
         oidx_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         mode_ff      <= mode_in;
         h_ff         <= h_in;
         fill_ff      <= fill_in;
         cnt_ff       <= cnt_in;
         rnd_ff       <= rnd_in;
         oidx_ff      <= oidx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff        <= v_in;
      blk_ff      <= blk_in;
      len_ff      <= len_in;
      rsp_word_ff <= rsp_word_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_digest_word = rsp_word_ff;
   assign rsp_word_index  = rsp_idx_ff;
   assign rsp_last        = rsp_last_ff;

   // round counter only moves during compression
   a_rnd_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_ROUND) |-> (rnd_ff == '0))
      else $error("round counter nonzero outside compression");

   // digest is read out only after the final block was absorbed
   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) |-> (fill_ff == '0))
      else $error("digest readout with a partial block");

   // length bytes land in the last eight byte slots
   a_len_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LEN) |-> (fill_ff[5:3] == 3'b111))
      else $error("length bytes out of place");

   // last marker only on the final word of either digest size
   a_last_idx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_last_ff) |-> (rsp_idx_ff == LAST_224 || rsp_idx_ff == LAST_256))
      else $error("last marker on an inner digest word");

   // entering compression starts from round zero
   a_rnd_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND) && $past(state_ff != ST_ROUND) |-> (rnd_ff == '0))
      else $error("compression entered mid round");

endmodule

>>> verif/tb_sha256_byte_hasher.sv
// self-checking testbench for the sha-256/224 byte hasher with a digest scoreboard
`timescale 1ns / 1ps

module tb_sha256_byte_hasher;

   import shabh_pkg::*;

   localparam int RANDOM_ITEMS  = 210;
   localparam int SETTLE_CYCLES = 80;
   localparam int END_CYCLES    = 160;
   localparam int HOLD_CYCLES   = 400;

   localparam logic [31:0] SHA_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] START_256 [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] START_224 [8] = '{
      32'hc1059ed8, 32'h367cd507, 32'h3070dd17, 32'hf70e5939,
      32'hffc00b31, 32'h68581511, 32'h64f98fa7, 32'hbefa4fa4
   };

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_word_type;

   class digest_scoreboard;
      logic        mode;
      logic [31:0] chain [8];
      logic [7:0]  blk [64];
      logic [5:0]  fill;
      logic [60:0] byte_count;
      digest_word_type pending [$];
      int n_inputs;
      int n_checked;
      int n_messages;
      int n_errors;

      function new();
         mode = MODE_256;
         n_inputs = 0;
         n_checked = 0;
         n_messages = 0;
         n_errors = 0;
         for (int i = 0; i < 64; i++) blk[i] = '0;
         restart();
      endfunction

      function void restart();
         for (int i = 0; i < 8; i++) begin
            chain[i] = (mode == MODE_224) ? START_224[i] : START_256[i];
         end
         fill = '0;
         byte_count = '0;
      endfunction

      function void set_mode(logic m);
         mode = m;
         restart();
      endfunction

      function logic [31:0] rotr(logic [31:0] x, int n);
         return (x >> n) | (x << (32 - n));
      endfunction

      function void compress();
         logic [31:0] w [16];
         logic [31:0] v [8];
         logic [31:0] t1, t2, s0, s1, w15, w2;
         int slot;
         for (int i = 0; i < 16; i++) begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
         end
         for (int i = 0; i < 8; i++) v[i] = chain[i];
         for (int r = 0; r < 64; r++) begin
            slot = r & 15;
            if (r >= 16) begin
               w15 = w[(slot + 1) & 15];
               w2  = w[(slot + 14) & 15];
               s0 = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
               s1 = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
               w[slot] = w[slot] + s0 + w[(slot + 9) & 15] + s1;
            end
            s1 = rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25);
            t1 = v[7] + s1 + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[slot];
            s0 = rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22);
            t2 = s0 + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6];
            v[6] = v[5];
            v[5] = v[4];
            v[4] = v[3] + t1;
            v[3] = v[2];
            v[2] = v[1];
            v[1] = v[0];
            v[0] = t1 + t2;
         end
         for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
      endfunction

      function void note_input(logic act, logic [7:0] b);
         int pos;
         int nw;
         logic [63:0] bits;
         digest_word_type dw;
         n_inputs++;
         if (act == ACT_ABSORB) begin
            blk[fill] = b;
            byte_count = byte_count + 61'd1;
            fill = fill + 6'd1;
            if (fill == 6'd0) compress();
            return;
         end
         pos = int'(fill);
         blk[pos] = PAD_MARK;
         pos++;
         // length no longer fits after the pad mark
         if (pos > 56) begin
            while (pos < 64) begin
               blk[pos] = '0;
               pos++;
            end
            compress();
            pos = 0;
         end
         while (pos < 56) begin
            blk[pos] = '0;
            pos++;
         end
         bits = {byte_count, 3'b000};
         for (int i = 0; i < 8; i++) blk[56 + i] = bits[63 - 8*i -: 8];
         compress();
         nw = (mode == MODE_224) ? 7 : 8;
         for (int i = 0; i < nw; i++) begin
            dw.word  = chain[i];
            dw.index = i[2:0];
            dw.last  = (i == nw - 1);
            pending.push_back(dw);
         end
         n_messages++;
         restart();
      endfunction

      function void check_result(logic [31:0] w, logic [2:0] idx, logic l);
         digest_word_type exp_w;
         if (pending.size() == 0) begin
            $error("digest word with none pending: word %h index %0d last %0b", w, idx, l);
            n_errors++;
            return;
         end
         exp_w = pending.pop_front();
         n_checked++;
         if (w !== exp_w.word) begin
            $error("digest_word mismatch: expected %h, actual %h", exp_w.word, w);
            n_errors++;
         end
         if (idx !== exp_w.index) begin
            $error("word_index mismatch: expected %0d, actual %0d", exp_w.index, idx);
            n_errors++;
         end
         if (l !== exp_w.last) begin
            $error("last mismatch: expected %0b, actual %0b", exp_w.last, l);
            n_errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_action = ACT_ABSORB;
   logic [7:0]  req_data_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_digest_mode = MODE_256;

   digest_scoreboard board = new();
   bit quiet = 1'b0;
   int hold_request = 0;
   int mode_writes = 0;

   sha256_byte_hasher dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last        (rsp_last),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_digest_mode (csr_digest_mode)
   );

   always #5 clock = ~clock;

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet) return 0;
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic int pick_len();
      int r;
      int edges [8] = '{55, 56, 57, 63, 64, 65, 119, 120};
      r = $urandom_range(0, 99);
      if (r < 55) return $urandom_range(0, 8);
      if (r < 75) return $urandom_range(9, 40);
      return edges[$urandom_range(0, 7)];
   endfunction

   task automatic send_item(input logic act, input logic [7:0] b);
      int g;
      req_valid     <= 1'b1;
      req_action    <= act;
      req_data_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_input(act, b);
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic send_message(input int len);
      for (int i = 0; i < len; i++) send_item(ACT_ABSORB, 8'($urandom));
      send_item(ACT_FINISH, 8'($urandom));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
   endtask

   task automatic write_mode(input logic m);
      wait_drained();
      // the block may still be compressing a block filled by the last byte
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_digest_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      board.set_mode(m);
      mode_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // result side: check each transaction and stall at random
   initial begin
      int stall;
      stall = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            board.check_result(rsp_digest_word, rsp_word_index, rsp_last);
         end
         if (hold_request > 0) begin
            stall = hold_request;
            hold_request = 0;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            stall = pick_gap();
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      #5ms;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int directed_items;
      int msg_no;
      int r;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty message, byte extremes, short known text
      send_item(ACT_FINISH, 8'hff);
      send_item(ACT_ABSORB, 8'h00);
      send_item(ACT_FINISH, 8'h00);
      send_item(ACT_ABSORB, 8'hff);
      send_item(ACT_FINISH, 8'h00);
      send_item(ACT_ABSORB, 8'h61);
      send_item(ACT_ABSORB, 8'h62);
      send_item(ACT_ABSORB, 8'h63);
      send_item(ACT_FINISH, 8'h00);
      write_mode(MODE_224);
      send_item(ACT_FINISH, 8'h00);
      send_item(ACT_ABSORB, 8'h80);
      send_item(ACT_FINISH, 8'hff);
      // mode write drops a message in progress
      send_item(ACT_ABSORB, 8'h12);
      send_item(ACT_ABSORB, 8'h34);
      send_item(ACT_ABSORB, 8'h56);
      write_mode(MODE_256);
      send_item(ACT_ABSORB, 8'h7f);
      send_item(ACT_FINISH, 8'h00);
      directed_items = board.n_inputs;

      msg_no = 0;
      while (board.n_inputs - directed_items < RANDOM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (msg_no == 2) begin
            // receiver holds off while two messages are sent; bytes wait while a digest is put out
            hold_request = HOLD_CYCLES;
            send_message(6);
            send_message(3);
         end else if (msg_no == 3) begin
            wait_drained();
         end else if (r < 8) begin
            write_mode(logic'($urandom_range(0, 1)));
         end else if (r < 14) begin
            for (int i = $urandom_range(1, 70); i > 0; i--) begin
               send_item(ACT_ABSORB, 8'($urandom));
            end
            write_mode(logic'($urandom_range(0, 1)));
         end else if (r < 20) begin
            wait_drained();
         end else begin
            send_message(pick_len());
         end
         if (msg_no == 5) quiet = 1'b1;
         if (msg_no == 9) quiet = 1'b0;
         msg_no++;
      end

      wait_drained();
      repeat (END_CYCLES) @(posedge clock);
      $display("%0d request transactions, %0d messages, %0d digest words checked",
               board.n_inputs, board.n_messages, board.n_checked);
      $display("%0d mode writes across sha-256 and sha-224, with padding edge lengths",
               mode_writes);
      if (board.n_errors == 0 && board.pending.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
